[rtl/smax_pkg.sv]
// shared types and constants of the sma crossover signal block
// no dependencies; imported by every rtl module of the block

package smax_pkg;

    // field and register widths
    localparam int PERIOD_BITS   = 9;
    localparam int PRICE_IN_BITS = 32;
    localparam int SIG_BITS      = 2;
    localparam int S_TDATA_BITS  = 32;
    localparam int M_TDATA_BITS  = 8;
    localparam int CFG_ADDR_BITS = 1;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FAST = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SLOW = 1'b1;

    // register reset values
    localparam logic [PERIOD_BITS-1:0] FAST_RESET = 9'd10;
    localparam logic [PERIOD_BITS-1:0] SLOW_RESET = 9'd30;

    // trade signal codes
    localparam logic [SIG_BITS-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIG_BITS-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_BITS-1:0] SIG_SELL = 2'd2;

    // relation of fast average to slow average
    localparam logic [1:0] REL_EQUAL = 2'd0;
    localparam logic [1:0] REL_ABOVE = 2'd1;
    localparam logic [1:0] REL_BELOW = 2'd2;
    localparam logic [1:0] REL_NONE  = 2'd3;

    // per-item flags carried down the pipeline
    typedef struct packed {
        logic cfg_ok;     // periods form a usable pair
        logic fast_full;  // fast window start lies in written history
        logic slow_full;  // slow window start lies in written history
        logic warm;       // slow window covered, relation is defined
    } ctl_t;

endpackage

[rtl/smax_ring.sv]
// price history stage: running total, ring of past totals, window base reads
// depends on smax_pkg

module smax_ring #(
    parameter int MAX_PERIOD = 256,
    parameter int PRICE_BITS = 32,
    parameter int SUM_BITS   = 40
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  logic [PRICE_BITS-1:0]              price_in,
    input  logic [smax_pkg::PERIOD_BITS-1:0]   fast_period,
    input  logic [smax_pkg::PERIOD_BITS-1:0]   slow_period,
    output logic [SUM_BITS-1:0]                total_out,
    output logic [SUM_BITS-1:0]                base_fast,
    output logic [SUM_BITS-1:0]                base_slow,
    output smax_pkg::ctl_t                     ctl_out
);
    import smax_pkg::*;

    localparam int PTR_BITS = $clog2(MAX_PERIOD);
    localparam int CNT_BITS = $clog2(MAX_PERIOD + 1);
    localparam int CMP_BITS = ((CNT_BITS > PERIOD_BITS) ? CNT_BITS : PERIOD_BITS) + 2;

    // ring holds the running total after each price
    logic [SUM_BITS-1:0] ring [MAX_PERIOD];

    logic [PTR_BITS-1:0] ptr_reg, ptr_next;
    logic [CNT_BITS-1:0] seen_reg, seen_next;
    logic [SUM_BITS-1:0] total_reg, total_next;
    logic [SUM_BITS-1:0] total_out_reg, base_fast_reg, base_slow_reg;
    ctl_t                ctl_reg, ctl_next;

    logic [CMP_BITS-1:0] seen_w, fast_w, slow_w, max_w, ptr_w;
    logic [CMP_BITS-1:0] dist_fast, dist_slow;
    logic [PTR_BITS-1:0] addr_fast, addr_slow;
    logic                cfg_ok;

    // slot that lies p entries behind the write pointer
    function automatic logic [CMP_BITS-1:0] back_slot(
        input logic [CMP_BITS-1:0] ptr,
        input logic [CMP_BITS-1:0] p,
        input logic [CMP_BITS-1:0] depth
    );
        logic [CMP_BITS-1:0] d;
        d = ptr - p;
        if (d[CMP_BITS-1]) begin
            d = d + depth;
        end
        return d;
    endfunction

    always_comb begin
        seen_w = CMP_BITS'(seen_reg);
        fast_w = CMP_BITS'(fast_period);
        slow_w = CMP_BITS'(slow_period);
        max_w  = CMP_BITS'(MAX_PERIOD);
        ptr_w  = CMP_BITS'(ptr_reg);
        cfg_ok = (fast_w != '0) && (slow_w != '0) && (fast_w < slow_w) && (slow_w <= max_w);

        dist_fast = back_slot(ptr_w, cfg_ok ? fast_w : '0, max_w);
        dist_slow = back_slot(ptr_w, cfg_ok ? slow_w : '0, max_w);
        addr_fast = dist_fast[PTR_BITS-1:0];
        addr_slow = dist_slow[PTR_BITS-1:0];

        ctl_next.cfg_ok    = cfg_ok;
        ctl_next.fast_full = seen_w >= fast_w;
        ctl_next.slow_full = seen_w >= slow_w;
        ctl_next.warm      = (seen_w + CMP_BITS'(1)) >= slow_w;

        total_next = total_reg + SUM_BITS'(price_in);
        ptr_next   = (ptr_reg == PTR_BITS'(MAX_PERIOD - 1)) ? '0 : ptr_reg + PTR_BITS'(1);
        seen_next  = (seen_reg < CNT_BITS'(MAX_PERIOD)) ? seen_reg + CNT_BITS'(1) : seen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            seen_reg  <= '0;
            total_reg <= '0;
        end else if (load) begin
            ptr_reg   <= ptr_next;
            seen_reg  <= seen_next;
            total_reg <= total_next;
        end
    end

    // a slot p back is read before this edge overwrites it
    always_ff @(posedge aclk) begin
        if (load) begin
            ring[ptr_reg] <= total_next;
            base_fast_reg <= ring[addr_fast];
            base_slow_reg <= ring[addr_slow];
            total_out_reg <= total_next;
            ctl_reg       <= ctl_next;
        end
    end

    assign total_out = total_out_reg;
    assign base_fast = base_fast_reg;
    assign base_slow = base_slow_reg;
    assign ctl_out   = ctl_reg;

endmodule

[rtl/smax_avg.sv]
// window sum stage and cross-multiply stage
// depends on smax_pkg

module smax_avg #(
    parameter int SUM_BITS = 40
) (
    input  logic                                        aclk,
    input  logic                                        load_sum,
    input  logic                                        load_mul,
    input  logic [SUM_BITS-1:0]                         total_in,
    input  logic [SUM_BITS-1:0]                         base_fast,
    input  logic [SUM_BITS-1:0]                         base_slow,
    input  smax_pkg::ctl_t                              ctl_in,
    input  logic [smax_pkg::PERIOD_BITS-1:0]            fast_period,
    input  logic [smax_pkg::PERIOD_BITS-1:0]            slow_period,
    output logic [SUM_BITS+smax_pkg::PERIOD_BITS-1:0]   prod_fast,
    output logic [SUM_BITS+smax_pkg::PERIOD_BITS-1:0]   prod_slow,
    output smax_pkg::ctl_t                              ctl_out
);
    import smax_pkg::*;

    localparam int PROD_BITS = SUM_BITS + PERIOD_BITS;

    logic [SUM_BITS-1:0]  fast_sum_reg, slow_sum_reg;
    logic [PROD_BITS-1:0] prod_fast_reg, prod_slow_reg;
    ctl_t                 ctl_sum_reg, ctl_mul_reg;

    // totals wrap, the difference is still the exact window sum
    always_ff @(posedge aclk) begin
        if (load_sum) begin
            fast_sum_reg <= total_in - (ctl_in.fast_full ? base_fast : '0);
            slow_sum_reg <= total_in - (ctl_in.slow_full ? base_slow : '0);
            ctl_sum_reg  <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_mul) begin
            prod_fast_reg <= PROD_BITS'(fast_sum_reg) * PROD_BITS'(slow_period);
            prod_slow_reg <= PROD_BITS'(slow_sum_reg) * PROD_BITS'(fast_period);
            ctl_mul_reg   <= ctl_sum_reg;
        end
    end

    assign prod_fast = prod_fast_reg;
    assign prod_slow = prod_slow_reg;
    assign ctl_out   = ctl_mul_reg;

endmodule

[rtl/smax_decide.sv]
// compare of averages, cross detection and result register
// depends on smax_pkg

module smax_decide #(
    parameter int PROD_BITS = 49
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  logic [PROD_BITS-1:0]            prod_fast,
    input  logic [PROD_BITS-1:0]            prod_slow,
    input  smax_pkg::ctl_t                  ctl_in,
    output logic [smax_pkg::SIG_BITS-1:0]   trade_signal
);
    import smax_pkg::*;

    logic [1:0]          prev_rel_reg, cur_rel;
    logic [SIG_BITS-1:0] sig_reg, sig_next;

    always_comb begin
        if (!(ctl_in.cfg_ok && ctl_in.warm)) begin
            cur_rel = REL_NONE;
        end else if (prod_fast > prod_slow) begin
            cur_rel = REL_ABOVE;
        end else if (prod_fast < prod_slow) begin
            cur_rel = REL_BELOW;
        end else begin
            cur_rel = REL_EQUAL;
        end

        sig_next = SIG_HOLD;
        if (ctl_in.cfg_ok && ctl_in.slow_full && prev_rel_reg != REL_NONE
                && cur_rel != REL_NONE) begin
            if (prev_rel_reg != REL_ABOVE && cur_rel == REL_ABOVE) begin
                sig_next = SIG_BUY;
            end else if (prev_rel_reg != REL_BELOW && cur_rel == REL_BELOW) begin
                sig_next = SIG_SELL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rel_reg <= REL_EQUAL;
        end else if (load) begin
            prev_rel_reg <= cur_rel;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sig_reg <= sig_next;
        end
    end

    assign trade_signal = sig_reg;

endmodule

[rtl/sma_crossover_signal.sv]
// top level of the sma crossover signal block: handshake, config registers, pipeline
// depends on smax_pkg, smax_ring, smax_avg, smax_decide
//
//  port group   dir  payload (lsb up)              notes
//  s_axis       in   tdata: close_price[31:0]      one candle close per request
//  m_axis       out  tdata: trade_signal[1:0], pad one result per candle
//  cfg          in   wdata: period[8:0]            index 0 fast, 1 slow
//
// one request per cycle sustained while m_tready holds; the result passes the input, ring,
// sum, product and signal registers; the rate follows from a single pass through each stage
// and one write plus two reads of the history ring per cycle
// synchronous active-low reset clears pointer, count, total, valids, last relation;
// the ring needs no clearing pass, unwritten slots are never used
// each stage takes a new request when it is empty or its content moves on, so
// bubbles collapse and a stalled output holds the pipeline behind it

module sma_crossover_signal #(
    parameter int MAX_PERIOD = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // close_price[31:0]
    input  logic [smax_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // trade_signal[1:0], zero pad above
    output logic [smax_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [smax_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [smax_pkg::PERIOD_BITS-1:0]    cfg_wdata
);
    import smax_pkg::*;

    // a window sum of up to MAX_PERIOD prices fits in these bits
    localparam int SUM_BITS  = PRICE_BITS + $clog2(MAX_PERIOD);
    localparam int PROD_BITS = SUM_BITS + PERIOD_BITS;

    // configuration registers
    logic [PERIOD_BITS-1:0] fast_reg, slow_reg;

    // stage valids: 0 input, 1 ring, 2 sums, 3 products; output is m_tvalid
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    logic [PRICE_BITS-1:0] price_reg;

    logic [SUM_BITS-1:0]  total_s1, base_fast_s1, base_slow_s1;
    ctl_t                 ctl_s1, ctl_s3;
    logic [PROD_BITS-1:0] prod_fast_s3, prod_slow_s3;
    logic [SIG_BITS-1:0]  sig_out;

    // ready chain from the output back to the input
    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_tready = rdy0;
    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(M_TDATA_BITS - SIG_BITS){1'b0}}, sig_out};

    // the user must write config only while no request is in flight; not enforced here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg <= FAST_RESET;
            slow_reg <= SLOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_FAST: fast_reg <= cfg_wdata;
                CFG_SLOW: slow_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // input register; only the low price bits are kept
    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy0) begin
            price_reg <= PRICE_BITS'(s_tdata);
        end
    end

    smax_ring #(
        .MAX_PERIOD (MAX_PERIOD),
        .PRICE_BITS (PRICE_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (v0_reg && rdy1),
        .price_in    (price_reg),
        .fast_period (fast_reg),
        .slow_period (slow_reg),
        .total_out   (total_s1),
        .base_fast   (base_fast_s1),
        .base_slow   (base_slow_s1),
        .ctl_out     (ctl_s1)
    );

    smax_avg #(
        .SUM_BITS (SUM_BITS)
    ) u_avg (
        .aclk        (aclk),
        .load_sum    (v1_reg && rdy2),
        .load_mul    (v2_reg && rdy3),
        .total_in    (total_s1),
        .base_fast   (base_fast_s1),
        .base_slow   (base_slow_s1),
        .ctl_in      (ctl_s1),
        .fast_period (fast_reg),
        .slow_period (slow_reg),
        .prod_fast   (prod_fast_s3),
        .prod_slow   (prod_slow_s3),
        .ctl_out     (ctl_s3)
    );

    smax_decide #(
        .PROD_BITS (PROD_BITS)
    ) u_decide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (v3_reg && rdy4),
        .prod_fast    (prod_fast_s3),
        .prod_slow    (prod_slow_s3),
        .ctl_in       (ctl_s3),
        .trade_signal (sig_out)
    );

`ifndef SYNTHESIS
    // input stalls only when every stage is full and the output is blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && m_tvalid && !m_tready))
        else $error("input stalled with a free pipeline slot");

    // reset leaves the pipeline empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("pipeline not empty after reset");

    // products waiting on a blocked output stay put
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(prod_fast_s3) && $stable(prod_slow_s3)))
        else $error("product stage changed while stalled");
`endif

endmodule
